@@ rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// types, constants and round functions shared by the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic {
    REQ_ABSORB = 1'b0,
    REQ_FINISH = 1'b1
  } req_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       wr_byte;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       load;
    logic       round;
    logic [5:0] rnd;
    logic       update;
    logic       reinit;
    logic [2:0] rd_idx;
  } dp_cmd_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha256_datapath.sv @@
// ----------------------------------------------------------------------------
// sha256_datapath
// byte-wise loaded rolling message schedule, working words and hash words
// ----------------------------------------------------------------------------
module sha256_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha256_pkg::dp_cmd_t  cmd_i,
  output logic [31:0]          hash_word_o
);

  logic [31:0] w_q [16];
  logic [31:0] wk_q [8];
  logic [31:0] h_q [8];

  logic [31:0] w_cur, s0, s1, t1, t2, w2, w7, w15, w16;
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [3:0]  wi;
  logic [4:0]  lane;

  assign wi   = cmd_i.rnd[3:0];
  assign lane = {~cmd_i.wr_addr[1:0], 3'b000};
  assign w2  = w_q[4'(wi - 4'd2)];
  assign w7  = w_q[4'(wi - 4'd7)];
  assign w15 = w_q[4'(wi - 4'd15)];
  assign w16 = w_q[wi];
  assign a = wk_q[0]; assign b = wk_q[1]; assign c = wk_q[2]; assign d = wk_q[3];
  assign e = wk_q[4]; assign f = wk_q[5]; assign g = wk_q[6]; assign h = wk_q[7];

  always_comb begin
    s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    w_cur = (cmd_i.rnd < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
    t1 = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
         + (g ^ (e & (f ^ g))) + sha256_pkg::ROUND_K[cmd_i.rnd] + w_cur;
    t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & b) | (c & (a | b)));
  end

  // bytes land big-endian in the schedule words, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      w_q[cmd_i.wr_addr[5:2]][lane +: 8] <= cmd_i.wr_data;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) begin
        wk_q[i] <= h_q[i];
      end
    end else if (cmd_i.round) begin
      w_q[wi] <= w_cur;
      for (int i = 1; i < 8; i++) begin
        if (i != 4) wk_q[i] <= wk_q[i-1];
      end
      wk_q[4] <= d + t1;
      wk_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_HASH[i];
    end else if (cmd_i.reinit) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_HASH[i];
    end else if (cmd_i.update) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + wk_q[i];
    end
  end

  assign hash_word_o = h_q[cmd_i.rd_idx];

endmodule

@@ rtl/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer for byte intake, padding, 64 rounds and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_idx_o,
  output sha256_pkg::dp_cmd_t   cmd_o
);

  sha256_pkg::state_e state_q, state_d;
  logic [63:0] cnt_q, cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  pad_q, pad_d;
  logic        fin_q, fin_d;     // finishing message
  logic        last_q, last_d;   // current block is the final one
  logic [2:0]  idx_q, idx_d;
  logic [63:0] bits;

  assign bits = cnt_q << 3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      cnt_q   <= '0;
      rnd_q   <= '0;
      pad_q   <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; rnd_d = rnd_q; pad_d = pad_q;
    fin_d = fin_q; last_d = last_q; idx_d = idx_q;
    cmd_o = '0;
    cmd_o.rnd = rnd_q;
    cmd_o.rd_idx = idx_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.req_type == sha256_pkg::REQ_ABSORB) begin
            cmd_o.wr_byte = 1'b1;
            cmd_o.wr_addr = cnt_q[5:0];
            cmd_o.wr_data = in_data_i.data_byte;
            cnt_d = cnt_q + 64'd1;
            if (cnt_q[5:0] == 6'd63) begin
              cmd_o.load = 1'b0;
              rnd_d = '0;
              fin_d = 1'b0;
              last_d = 1'b0;
              state_d = sha256_pkg::ST_UPDATE;
              pad_d = 6'd0;
            end
          end else begin
            cmd_o.wr_byte = 1'b1;
            cmd_o.wr_addr = cnt_q[5:0];
            cmd_o.wr_data = sha256_pkg::PAD_BYTE;
            pad_d = 6'(cnt_q[5:0] + 6'd1);
            fin_d = 1'b1;
            last_d = (cnt_q[5:0] < 6'd56);
            state_d = (cnt_q[5:0] == 6'd63) ? sha256_pkg::ST_UPDATE : sha256_pkg::ST_PAD;
          end
        end
      end
      // write zeros and length, one byte a cycle
      sha256_pkg::ST_PAD: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.wr_addr = pad_q;
        if (last_q && pad_q >= sha256_pkg::LEN_START) begin
          cmd_o.wr_data = bits[8*(7-(pad_q[2:0]))+:8];
        end else begin
          cmd_o.wr_data = 8'h00;
        end
        pad_d = pad_q + 6'd1;
        if (pad_q == 6'd63) begin
          state_d = sha256_pkg::ST_UPDATE;
        end
      end
      // load working words from hash words, or fold them back in
      sha256_pkg::ST_UPDATE: begin
        if (rnd_q == 6'd0 && !idx_q[0]) begin
          cmd_o.load = 1'b1;
          idx_d = 3'd1;
          state_d = sha256_pkg::ST_ROUND;
        end else begin
          cmd_o.update = 1'b1;
          idx_d = '0;
          rnd_d = '0;
          if (!fin_q) begin
            state_d = sha256_pkg::ST_IDLE;
          end else if (!last_q) begin
            last_d = 1'b1;
            pad_d = '0;
            state_d = sha256_pkg::ST_PAD;
          end else begin
            state_d = sha256_pkg::ST_EMIT;
          end
        end
      end
      sha256_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            cnt_d = '0;
            fin_d = 1'b0;
            state_d = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  assign out_idx_o = idx_q;

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256: one message byte per input beat, eight digest beats out
// ----------------------------------------------------------------------------
// An absorb beat writes one byte into the schedule; the 64th byte of a block
// adds a load step, 64 rounds (one round per cycle through a single round
// unit) and a hash update step. A finish beat pads one byte per cycle up to
// the block end, compresses, possibly a second padded block, then presents
// eight digest beats, one per accepted cycle. Input is not accepted while
// padding, while a block compresses or while the digest drains.
module sha256_stream_hasher (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sha256_pkg::in_beat_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sha256_pkg::out_beat_t  out_data_o
);

  sha256_pkg::dp_cmd_t cmd;
  logic [31:0] hword;
  logic [2:0]  idx;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_idx_o(idx), .cmd_o(cmd)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .hash_word_o(hword)
  );

  assign out_data_o.digest_word = hword;
  assign out_data_o.word_index  = idx;
  assign out_data_o.last_word   = (idx == 3'd7);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx != 3'd7) |=> out_valid_o)
    else $error("digest cut short");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx == 3'd7) |=> in_ready_o)
    else $error("no return to idle");

endmodule
